FILE: sv/abst_pkg.sv
// shared constants, types and helpers for the array bst insert/search unit
package abst_pkg;

    localparam int LEVELS      = 10;
    localparam int KEY_BITS    = 32;
    localparam int IN_KEY_W    = 32;
    localparam int HEIGHT_W    = 4;
    localparam int SLOTS       = 1 << LEVELS;
    localparam int ADDR_W      = LEVELS;
    localparam int LVL_W       = $clog2(LEVELS + 1);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef logic [KEY_BITS-1:0] t_key;

    // classified item handed from the front queue to the walker
    typedef struct packed {
        t_cmd cmd;
        logic zero;
        t_key key;
    } t_q_item;

    // status the walker reports back to the front
    typedef struct packed {
        logic clearing;
    } t_back_status;

    // low KEY_BITS bits of the incoming key, sign extended first if wider
    function automatic t_key key_of(logic signed [IN_KEY_W-1:0] k);
        logic signed [KEY_BITS+IN_KEY_W-1:0] w;
        w = (KEY_BITS + IN_KEY_W)'(k);
        return w[KEY_BITS-1:0];
    endfunction

    // level count reported modulo 16
    function automatic logic [HEIGHT_W-1:0] to_height(logic [LVL_W-1:0] l);
        logic [LVL_W+HEIGHT_W-1:0] w;
        w = {{HEIGHT_W{1'b0}}, l};
        return w[HEIGHT_W-1:0];
    endfunction

endpackage

FILE: sv/abst_if.sv
// valid/ready channel interfaces for items and results
interface abst_in_if
    import abst_pkg::*;
();
    logic                       valid;
    logic                       ready;
    logic                       command;
    logic signed [IN_KEY_W-1:0] key;

    modport source (output valid, output command, output key, input ready);
    modport sink   (input valid, input command, input key, output ready);
endinterface

interface abst_out_if
    import abst_pkg::*;
();
    logic                valid;
    logic                ready;
    logic                found;
    logic                stored;
    logic                overflow;
    logic [HEIGHT_W-1:0] tree_height;

    modport source (output valid, output found, output stored, output overflow,
                    output tree_height, input ready);
    modport sink   (input valid, input found, input stored, input overflow,
                    input tree_height, output ready);
endinterface

FILE: sv/abst_ram.sv
// generic single write, single read ram with registered read data
module abst_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: sv/abst_front.sv
// front end: accepts items, classifies them and queues them for the walker
module abst_front
    import abst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    abst_in_if.sink      i_in,
    input  t_back_status i_status,
    output logic         o_q_valid,
    output t_q_item      o_q_item,
    input  logic         i_q_pop
);
    t_q_item           r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic              push;
    logic              pop;
    t_q_item           n_item;

    assign i_in.ready = (r_count < QCNT_W'(QUEUE_DEPTH)) && !i_status.clearing;
    assign push       = i_in.valid && i_in.ready;
    assign pop        = i_q_pop && (r_count != '0);

    always_comb begin
        n_item.cmd  = t_cmd'(i_in.command);
        n_item.key  = key_of(i_in.key);
        n_item.zero = (n_item.key == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_q[r_wr_ptr] <= n_item;
                r_wr_ptr <= (r_wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_q_valid = (r_count != '0);
    assign o_q_item  = r_q[r_rd_ptr];
endmodule

FILE: sv/abst_back.sv
// back end: clears the node store, walks the tree and registers the result
module abst_back
    import abst_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_q_item      i_q_item,
    output logic         o_q_pop,
    output t_back_status o_status,
    abst_out_if.source   o_out
);
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK
    } t_state;

    t_state              r_state;
    logic [ADDR_W-1:0]   r_clr_addr;
    logic [ADDR_W-1:0]   r_slot;
    logic [LVL_W-1:0]    r_level;
    t_cmd                r_cmd;
    t_key                r_key;
    logic [LVL_W-1:0]    r_max_height;
    logic                r_out_valid;
    logic                r_found;
    logic                r_stored;
    logic                r_ovf;
    logic [HEIGHT_W-1:0] r_height;

    t_key              here;
    logic              hit;
    logic              empty;
    logic              go_left;
    logic              last;
    logic              done;
    logic              out_free;
    logic              pop;
    logic [ADDR_W-1:0] child;
    logic              do_store;
    logic [LVL_W-1:0]  n_max_height;
    logic              n_out_valid;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_key              wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;

    abst_ram #(
        .WIDTH (KEY_BITS),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (here)
    );

    assign hit      = (here == r_key);
    assign empty    = (here == '0);
    assign go_left  = $signed(r_key) < $signed(here);
    assign child    = {r_slot[ADDR_W-2:0], ~go_left};
    assign last     = (r_level == LVL_W'(LEVELS));
    assign done     = hit || empty || last;
    assign do_store = (r_state == ST_WALK) && empty && (r_cmd == CMD_INSERT);
    assign n_max_height = (do_store && (r_level > r_max_height)) ? r_level : r_max_height;

    assign out_free = !r_out_valid || o_out.ready;
    assign pop      = (r_state == ST_IDLE) && i_q_valid && out_free;
    assign o_q_pop  = pop;
    assign o_status.clearing = (r_state == ST_CLEAR);

    // a new result loads the register, otherwise it holds until its transfer
    assign n_out_valid = (pop && i_q_item.zero) || ((r_state == ST_WALK) && done) ||
                         (r_out_valid && !o_out.ready);

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_slot;
        wr_data = r_key;
        rd_en   = 1'b0;
        rd_addr = ADDR_W'(1);
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                wr_data = '0;
            end
            ST_IDLE: begin
                // root read goes out as the item leaves the queue
                rd_en = pop && !i_q_item.zero;
            end
            ST_WALK: begin
                wr_en   = do_store;
                rd_en   = !done;
                rd_addr = child;
            end
            default: begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_CLEAR;
            r_clr_addr   <= '0;
            r_max_height <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            case (r_state)
                ST_CLEAR: begin
                    r_clr_addr <= r_clr_addr + 1'b1;
                    if (r_clr_addr == ADDR_W'(SLOTS - 1)) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (pop) begin
                        r_cmd   <= i_q_item.cmd;
                        r_key   <= i_q_item.key;
                        r_slot  <= ADDR_W'(1);
                        r_level <= LVL_W'(1);
                        if (i_q_item.zero) begin
                            r_found     <= 1'b0;
                            r_stored    <= 1'b0;
                            r_ovf       <= 1'b0;
                            r_height    <= to_height(r_max_height);
                        end else begin
                            r_state <= ST_WALK;
                        end
                    end
                end
                ST_WALK: begin
                    if (done) begin
                        r_state      <= ST_IDLE;
                        r_max_height <= n_max_height;
                        r_found      <= hit;
                        r_stored     <= do_store;
                        r_ovf        <= !hit && !empty && (r_cmd == CMD_INSERT);
                        r_height     <= to_height(n_max_height);
                    end else begin
                        r_slot  <= child;
                        r_level <= r_level + 1'b1;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.found       = r_found;
    assign o_out.stored      = r_stored;
    assign o_out.overflow    = r_ovf;
    assign o_out.tree_height = r_height;
endmodule

FILE: sv/array_bst_insert_search_unit.sv
// top level of the array bst insert/search unit
// path: an item waits in the front queue, then the walker reads one node per level visited
// (up to 10 levels) and registers the result; a zero key skips the walk and is answered as it
// leaves the queue; one item walks at a time through the single node-store read port, and the
// next leaves the queue only once the result register is free; reset: a clearing pass writes all
// 1024 slots, no item is taken until it ends; queue, height and output valid are cleared at once
module array_bst_insert_search_unit
    import abst_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    abst_in_if.sink    i_in,
    abst_out_if.source o_out
);
    logic         q_valid;
    t_q_item      q_item;
    logic         q_pop;
    t_back_status status;

    abst_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_status  (status),
        .o_q_valid (q_valid),
        .o_q_item  (q_item),
        .i_q_pop   (q_pop)
    );

    abst_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_status  (status),
        .o_out     (o_out)
    );
endmodule

FILE: sv/abst_checker.sv
// port-level assertions for the array bst insert/search unit, bound to the top level
module abst_checker
    import abst_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                i_in_ready,
    input logic                i_out_valid,
    input logic                i_out_ready,
    input logic                i_found,
    input logic                i_stored,
    input logic                i_overflow,
    input logic [HEIGHT_W-1:0] i_tree_height
);
    logic [7:0] r_pend;

    // items taken in but not yet delivered
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            case ({i_in_valid && i_in_ready, i_out_valid && i_out_ready})
                2'b10:   r_pend <= r_pend + 1'b1;
                2'b01:   r_pend <= r_pend - 1'b1;
                default: r_pend <= r_pend;
            endcase
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> (i_out_valid && $stable(i_found) &&
        $stable(i_stored) && $stable(i_overflow) && $stable(i_tree_height)))
        else $error("result changed while stalled");

    a_no_invented: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (r_pend != '0))
        else $error("result without a pending transfer");

    a_height_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready) |=> (!i_out_valid ||
        (i_tree_height >= $past(i_tree_height))))
        else $error("tree height went down");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && (i_stored || i_overflow)) |->
        (!i_found && !(i_stored && i_overflow) && (!i_stored || i_tree_height != '0)))
        else $error("inconsistent result flags");
endmodule

bind array_bst_insert_search_unit abst_checker u_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in.valid),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_found       (o_out.found),
    .i_stored      (o_out.stored),
    .i_overflow    (o_out.overflow),
    .i_tree_height (o_out.tree_height)
);

FILE: dv/array_bst_insert_search_checker.sv
`timescale 1ns / 100ps
// channel monitor, tree predictor and result checker for the array bst unit
module array_bst_insert_search_checker
    import abst_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    abst_in_if   i_in,
    abst_out_if  i_out,
    output int   o_errors,
    output int   o_pending,
    output int   o_hits,
    output int   o_stored,
    output int   o_overflows,
    output int   o_peak
);

    typedef struct packed {
        logic                found;
        logic                stored;
        logic                overflow;
        logic [HEIGHT_W-1:0] height;
    } t_bst_answer;

    t_key        slot_keys [SLOTS];
    int          peak_level;
    t_bst_answer answers [$];

    initial begin
        o_errors    = 0;
        o_pending   = 0;
        o_hits      = 0;
        o_stored    = 0;
        o_overflows = 0;
        o_peak      = 0;
    end

    // walk the tree from the root, update the shadow store, return the answer
    function automatic t_bst_answer walk_tree(t_cmd cmd, t_key key);
        t_bst_answer ans;
        int          slot;
        int          depth;
        bit          hit;
        bit          room;
        ans = '0;
        if (key != '0) begin
            slot  = 1;
            depth = 1;
            hit   = 1'b0;
            room  = 1'b0;
            while (depth <= LEVELS && !hit && !room) begin
                if (slot_keys[slot] == '0) begin
                    room = 1'b1;
                end else if (slot_keys[slot] == key) begin
                    hit = 1'b1;
                end else begin
                    slot  = 2 * slot + (($signed(key) < $signed(slot_keys[slot])) ? 0 : 1);
                    depth = depth + 1;
                end
            end
            ans.found = hit;
            if (cmd == CMD_INSERT && !hit) begin
                if (room) begin
                    slot_keys[slot] = key;
                    ans.stored = 1'b1;
                    if (depth > peak_level) peak_level = depth;
                end else begin
                    ans.overflow = 1'b1;
                end
            end
        end
        ans.height = HEIGHT_W'(peak_level);
        return ans;
    endfunction

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            o_errors++;
            $error("%s mismatch: expected %0d, actual %0d", name, want, got);
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_bst_answer got;
        t_bst_answer want;
        if (!i_rst_n) begin
            foreach (slot_keys[s]) slot_keys[s] = '0;
            peak_level = 0;
            answers.delete();
        end else begin
            // result side first: a result can never belong to a same-cycle transfer
            if (i_out.valid && i_out.ready) begin
                got = '{i_out.found, i_out.stored, i_out.overflow, i_out.tree_height};
                if (answers.size() == 0) begin
                    o_errors++;
                    $error("result transfer with no pending expectation");
                end else begin
                    want = answers.pop_front();
                    check_field("found", want.found, got.found);
                    check_field("stored", want.stored, got.stored);
                    check_field("overflow", want.overflow, got.overflow);
                    check_field("tree_height", want.height, got.height);
                end
            end
            if (i_in.valid && i_in.ready) begin
                want = walk_tree(t_cmd'(i_in.command), t_key'(i_in.key));
                answers.push_back(want);
                o_hits      += want.found;
                o_stored    += want.stored;
                o_overflows += want.overflow;
                o_peak       = peak_level;
            end
        end
        o_pending = answers.size();
    end

endmodule

FILE: dv/array_bst_insert_search_unit_test.sv
`timescale 1ns / 100ps
// stimulus, handshake idling and verdict for the array bst insert/search unit
module array_bst_insert_search_unit_test;
    import abst_pkg::*;

    localparam int   RANDOM_ITEMS = 1600;
    localparam int   QUIET_ITEMS  = 300;
    localparam int   HOLD_AT_ITEM = 300;
    localparam int   LONG_HOLD    = 300;
    localparam int   CYCLE_LIMIT  = 400_000;
    localparam t_key KEY_MIN      = {1'b1, {(KEY_BITS-1){1'b0}}};
    localparam t_key KEY_MAX      = {1'b0, {(KEY_BITS-1){1'b1}}};

    logic i_clk;
    logic i_rst_n;

    abst_in_if  in_ch ();
    abst_out_if out_ch ();

    int   errors;
    int   pending;
    int   hits;
    int   stored;
    int   overflows;
    int   peak;
    int   n_inserts;
    int   n_searches;
    bit   idling_on;
    bit   hold_req;
    t_key key_pool [$];

    array_bst_insert_search_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    array_bst_insert_search_checker checker_inst (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (in_ch),
        .i_out       (out_ch),
        .o_errors    (errors),
        .o_pending   (pending),
        .o_hits      (hits),
        .o_stored    (stored),
        .o_overflows (overflows),
        .o_peak      (peak)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT, pending);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial begin : receiver
        bit want_hold;
        bit may_stall;
        out_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            want_hold = hold_req;
            may_stall = idling_on;
            @(negedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready = 1'b0;
            end else if (want_hold) begin
                out_ch.ready = 1'b0;
                for (int c = 1; c < LONG_HOLD; c++) @(negedge i_clk);
                hold_req = 1'b0;
            end else if (may_stall && $urandom_range(0, 4) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
            end
        end
    end

    // one transfer on the item channel; valid stays high into the next call
    task automatic send_item(t_cmd cmd, t_key key);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 12)) @(negedge i_clk);
        end
        in_ch.valid   = 1'b1;
        in_ch.command = cmd;
        in_ch.key     = key;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
        if (cmd == CMD_INSERT) begin
            n_inserts++;
            if (key != '0) key_pool.push_back(key);
        end else begin
            n_searches++;
        end
    endtask

    // mix of known keys, their neighbors, keys near zero, extremes and wide random keys
    function automatic t_key pick_key();
        int   r;
        t_key k;
        r = $urandom_range(0, 99);
        if (key_pool.size() != 0 && r < 35) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
        end else if (key_pool.size() != 0 && r < 50) begin
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
            k = $urandom_range(0, 1) ? t_key'(k + 1) : t_key'(k - 1);
        end else if (r < 62) begin
            k = t_key'(int'($urandom_range(0, 100)) - 50);
        end else if (r < 68) begin
            case ($urandom_range(0, 4))
                0:       k = '0;
                1:       k = KEY_MIN;
                2:       k = KEY_MAX;
                3:       k = '1;
                default: k = t_key'(1);
            endcase
        end else begin
            k = t_key'($urandom());
        end
        return k;
    endfunction

    initial begin : stimulus
        t_cmd cmd;
        i_rst_n       = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.command = CMD_INSERT;
        in_ch.key     = '0;
        idling_on     = 1'b1;
        hold_req      = 1'b0;
        n_inserts     = 0;
        n_searches    = 0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        // empty tree, zero keys, extremes and a duplicate
        send_item(CMD_SEARCH, '0);
        send_item(CMD_INSERT, '0);
        send_item(CMD_SEARCH, t_key'(5));
        send_item(CMD_INSERT, KEY_MIN);
        send_item(CMD_INSERT, KEY_MAX);
        send_item(CMD_INSERT, '1);
        send_item(CMD_INSERT, t_key'(1));
        send_item(CMD_INSERT, KEY_MAX);
        send_item(CMD_SEARCH, KEY_MIN);
        send_item(CMD_SEARCH, t_key'(2));
        // descending chain under the right spine fills one path to the last level, then overflows
        for (int i = 1; i <= LEVELS - 3; i++) send_item(CMD_INSERT, t_key'(KEY_MAX - i));
        send_item(CMD_SEARCH, t_key'(KEY_MAX - (LEVELS - 2)));
        send_item(CMD_SEARCH, t_key'(KEY_MAX - (LEVELS - 4)));
        send_item(CMD_INSERT, t_key'(KEY_MAX - (LEVELS - 4)));
        send_item(CMD_INSERT, t_key'(KEY_MAX - (LEVELS - 2)));

        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == HOLD_AT_ITEM) hold_req = 1'b1;
            if (n == RANDOM_ITEMS - QUIET_ITEMS) idling_on = 1'b0;
            cmd = ($urandom_range(0, 99) < 55) ? CMD_INSERT : CMD_SEARCH;
            send_item(cmd, pick_key());
        end
        in_ch.valid = 1'b0;

        while (pending != 0) @(negedge i_clk);
        repeat (LEVELS + 8) @(posedge i_clk);

        $display("sent %0d inserts and %0d searches; %0d keys stored, %0d hits, %0d overflows",
                 n_inserts, n_searches, stored, hits, overflows);
        $display("deepest level in use %0d; result side held off once for %0d cycles",
                 peak, LONG_HOLD);
        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
